// ===== hdl/mesh_unit_box_normalizer_macros.svh =====
// Assertion macros for the mesh unit box normalizer.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef MESH_UNIT_BOX_NORMALIZER_MACROS_SVH
`define MESH_UNIT_BOX_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MUBN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mubn: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define MUBN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mubn: next-cycle check failed");

`endif

// ===== hdl/mubn_pkg.sv =====
// Shared types and constants for the mesh unit box normalizer.
// No dependencies.
package mubn_pkg;

    localparam int POS_W          = 32;
    localparam int NORM_W         = 16;
    localparam int POS_FRAC_BITS  = 16;
    localparam int NORM_FRAC_BITS = 14;

    // request action codes
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_APPLY   = 1'b1;

    // divider: numerator = (|d2| << frac) + m, denominator = 2m
    localparam int MAG_W  = POS_W + 2;
    localparam int NUM_W  = MAG_W + POS_FRAC_BITS + 1;
    localparam int DEN_W  = POS_W + 1;
    localparam int CNT_W  = $clog2(NUM_W);

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // normal rescale search
    localparam int R_W    = NORM_FRAC_BITS + 1;
    localparam int B_W    = $clog2(NORM_FRAC_BITS + 1);
    localparam int RHS_W  = PROD_W - 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT,
        S_DIV_GO,
        S_DIV_RUN,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SQ_E,
        S_A_ISS,
        S_A_CAP,
        S_K_ISS,
        S_KL_ISS,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hdl/mubn_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on mubn_pkg.
module mubn_mul (
    input  logic                       i_clk,
    input  logic [mubn_pkg::MUL_W-1:0] i_a,
    input  logic [mubn_pkg::MUL_W-1:0] i_b,
    output logic [mubn_pkg::PROD_W-1:0] o_prod
);
    import mubn_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // one product per cycle, ready next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= {{MUL_W{1'b0}}, i_a} * {{MUL_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;
endmodule

// ===== hdl/mubn_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on mubn_pkg.
module mubn_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mubn_pkg::t_div_req         i_req,
    output mubn_pkg::t_div_stat        o_stat,
    output logic [mubn_pkg::NUM_W-1:0] o_quo
);
    import mubn_pkg::*;

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   trial;
    logic             fits;

    // shift in next numerator bit, subtract when it fits
    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        fits   = trial >= {1'b0, r_den};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], fits};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
endmodule

// ===== hdl/mesh_unit_box_normalizer.sv =====
// Mesh unit box normalizer: measure pass folds vertices into a box, apply
// pass centers, scales by the largest extent and renormalizes the normal.
// Measure request: one per cycle while no apply is in progress. Apply request:
// one divider run per axis, then a bitwise search per normal component, which
// a zero-length normal skips; o_stall drops as the result is registered out.
// Synchronous active-low reset empties the box (min high, max low).
module mesh_unit_box_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic        i_start_req,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_norm_x,
    input  logic signed [15:0] i_norm_y,
    input  logic signed [15:0] i_norm_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [15:0] o_out_norm_x,
    output logic signed [15:0] o_out_norm_y,
    output logic signed [15:0] o_out_norm_z,
    output logic        o_zero_normal
);
    import mubn_pkg::*;
    `include "mesh_unit_box_normalizer_macros.svh"

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [R_W-1:0]          LIM     = R_W'(1) << NORM_FRAC_BITS;

    t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;

    logic signed [POS_W-1:0]  r_bmin [3], n_bmin [3];
    logic signed [POS_W-1:0]  r_bmax [3], n_bmax [3];
    logic signed [POS_W-1:0]  r_pos  [3], n_pos  [3];
    logic signed [NORM_W-1:0] r_nrm  [3], n_nrm  [3];

    logic [POS_W-1:0]  r_m, n_m;
    logic              r_neg, n_neg;
    logic [POS_W-1:0]  r_len2, n_len2;
    logic [RHS_W-1:0]  r_rhs, n_rhs;
    logic [R_W-1:0]    r_r, n_r;
    logic [B_W-1:0]    r_b, n_b;

    logic [POS_W-1:0]  r_wpos [3], n_wpos [3];
    logic [NORM_W-1:0] r_wnrm [3], n_wnrm [3];
    logic              r_wzero, n_wzero;

    logic [POS_W-1:0]  r_opos [3], n_opos [3];
    logic [NORM_W-1:0] r_onrm [3], n_onrm [3];
    logic              r_ozero, n_ozero;
    logic              r_ovalid, n_ovalid;

    t_div_req           div_req;
    t_div_stat          div_stat;
    logic [NUM_W-1:0]   div_quo;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;

    logic                    acc;
    logic signed [POS_W:0]   ext [3];
    logic signed [POS_W:0]   emax;
    logic signed [POS_W:0]   csum;
    logic signed [MAG_W-1:0] d2;
    logic [MAG_W-1:0]        mag;
    logic [NORM_W-1:0]       nabs [3];
    logic [R_W-1:0]          t;
    logic [R_W:0]            k;
    logic [R_W-1:0]          pick;
    logic [POS_W-1:0]        len2_sum;
    logic                    onrm_clear;

    assign acc = i_valid && !o_stall;

    mubn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    mubn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // extents, per-axis offset and normal magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext[i]  = {r_bmax[i][POS_W-1], r_bmax[i]} - {r_bmin[i][POS_W-1], r_bmin[i]};
            nabs[i] = r_nrm[i][NORM_W-1] ? NORM_W'(-r_nrm[i]) : r_nrm[i];
        end
        emax = ext[0];
        if (ext[1] > emax) emax = ext[1];
        if (ext[2] > emax) emax = ext[2];
        csum = {r_bmax[r_axis][POS_W-1], r_bmax[r_axis]}
             + {r_bmin[r_axis][POS_W-1], r_bmin[r_axis]};
        d2   = {r_pos[r_axis][POS_W-1], r_pos[r_axis], 1'b0}
             - {csum[POS_W], csum};
        mag  = d2[MAG_W-1] ? MAG_W'(-d2) : d2;
        t    = r_r | (R_W'(1) << r_b);
        k    = {t, 1'b0} - 1'b1;
        len2_sum = r_len2 + mul_p[POS_W-1:0];
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_bmin   = r_bmin;
        n_bmax   = r_bmax;
        n_pos    = r_pos;
        n_nrm    = r_nrm;
        n_m      = r_m;
        n_neg    = r_neg;
        n_len2   = r_len2;
        n_rhs    = r_rhs;
        n_r      = r_r;
        n_b      = r_b;
        n_wpos   = r_wpos;
        n_wnrm   = r_wnrm;
        n_wzero  = r_wzero;
        n_opos   = r_opos;
        n_onrm   = r_onrm;
        n_ozero  = r_ozero;
        n_ovalid = r_ovalid && i_stall;
        div_req  = '0;
        mul_a    = '0;
        mul_b    = '0;
        pick     = r_r;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_pos = '{i_pos_x, i_pos_y, i_pos_z};
                    n_nrm = '{i_norm_x, i_norm_y, i_norm_z};
                    if (i_action == ACT_MEASURE) begin
                        for (int i = 0; i < 3; i++) begin
                            if (i_start_req) begin
                                n_bmin[i] = n_pos[i];
                                n_bmax[i] = n_pos[i];
                            end else begin
                                if (n_pos[i] < r_bmin[i]) n_bmin[i] = n_pos[i];
                                if (n_pos[i] > r_bmax[i]) n_bmax[i] = n_pos[i];
                            end
                        end
                    end else begin
                        n_state = S_EXT;
                    end
                end
            end
            S_EXT: begin
                n_m     = (emax < 1) ? POS_W'(1) : emax[POS_W-1:0];
                n_axis  = '0;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, mag, {POS_FRAC_BITS{1'b0}}}
                              + NUM_W'(r_m);
                div_req.den   = {r_m, 1'b0};
                n_neg         = d2[MAG_W-1];
                n_state       = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (div_stat.done) begin
                    // saturate to the signed 32-bit range
                    if (r_neg) begin
                        n_wpos[r_axis] = (div_quo > {{(NUM_W-POS_W){1'b0}}, POS_MIN})
                                       ? POS_MIN : POS_W'(-div_quo[POS_W-1:0]);
                    end else begin
                        n_wpos[r_axis] = (div_quo > NUM_W'(POS_MAX))
                                       ? POS_MAX : div_quo[POS_W-1:0];
                    end
                    if (r_axis == 2'd2) begin
                        n_state = S_SQ_X;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_SQ_X: begin
                mul_a   = MUL_W'(nabs[0]);
                mul_b   = MUL_W'(nabs[0]);
                n_state = S_SQ_Y;
            end
            S_SQ_Y: begin
                mul_a   = MUL_W'(nabs[1]);
                mul_b   = MUL_W'(nabs[1]);
                n_len2  = mul_p[POS_W-1:0];
                n_state = S_SQ_Z;
            end
            S_SQ_Z: begin
                mul_a   = MUL_W'(nabs[2]);
                mul_b   = MUL_W'(nabs[2]);
                n_len2  = len2_sum;
                n_state = S_SQ_E;
            end
            S_SQ_E: begin
                n_len2 = len2_sum;
                n_axis = '0;
                if (len2_sum == '0) begin
                    n_wnrm  = '{default: '0};
                    n_wzero = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_wzero = 1'b0;
                    n_state = S_A_ISS;
                end
            end
            S_A_ISS: begin
                mul_a   = MUL_W'(nabs[r_axis]);
                mul_b   = MUL_W'(nabs[r_axis]);
                n_state = S_A_CAP;
            end
            S_A_CAP: begin
                // rhs = 4 a^2 << 2*frac
                n_rhs   = RHS_W'({mul_p[POS_W-1:0], {(2*NORM_FRAC_BITS+2){1'b0}}});
                n_r     = '0;
                n_b     = B_W'(NORM_FRAC_BITS);
                n_state = S_K_ISS;
            end
            S_K_ISS: begin
                mul_a   = MUL_W'(k);
                mul_b   = MUL_W'(k);
                n_state = S_KL_ISS;
            end
            S_KL_ISS: begin
                mul_a   = mul_p[MUL_W-1:0];
                mul_b   = r_len2;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (t <= LIM && mul_p <= PROD_W'(r_rhs)) pick = t;
                n_r = pick;
                if (r_b == '0) begin
                    n_wnrm[r_axis] = r_nrm[r_axis][NORM_W-1]
                                   ? NORM_W'(-{1'b0, pick}) : NORM_W'(pick);
                    if (r_axis == 2'd2) begin
                        n_state = S_FIN;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_A_ISS;
                    end
                end else begin
                    n_b     = r_b - 1'b1;
                    n_state = S_K_ISS;
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_ovalid || !i_stall) begin
                    n_opos   = r_wpos;
                    n_onrm   = r_wnrm;
                    n_ozero  = r_wzero;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_ovalid <= 1'b0;
            r_bmin   <= '{default: POS_MAX};
            r_bmax   <= '{default: POS_MIN};
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_ovalid <= n_ovalid;
            r_bmin   <= n_bmin;
            r_bmax   <= n_bmax;
        end
        r_pos   <= n_pos;
        r_nrm   <= n_nrm;
        r_m     <= n_m;
        r_neg   <= n_neg;
        r_len2  <= n_len2;
        r_rhs   <= n_rhs;
        r_r     <= n_r;
        r_b     <= n_b;
        r_wpos  <= n_wpos;
        r_wnrm  <= n_wnrm;
        r_wzero <= n_wzero;
        r_opos  <= n_opos;
        r_onrm  <= n_onrm;
        r_ozero <= n_ozero;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_out_pos_x   = r_opos[0];
    assign o_out_pos_y   = r_opos[1];
    assign o_out_pos_z   = r_opos[2];
    assign o_out_norm_x  = r_onrm[0];
    assign o_out_norm_y  = r_onrm[1];
    assign o_out_norm_z  = r_onrm[2];
    assign o_zero_normal = r_ozero;
    assign onrm_clear    = (r_onrm[0] == '0) && (r_onrm[1] == '0) && (r_onrm[2] == '0);

    // an apply request always starts the sequencer
    `MUBN_ASSERT_NEXT(a_apply_busy, acc && (i_action == ACT_APPLY), o_stall)
    // a measure request never occupies the sequencer
    `MUBN_ASSERT_NEXT(a_measure_free, acc && (i_action == ACT_MEASURE), !o_stall)
    // a zero-length normal yields an all-zero normal
    `MUBN_ASSERT_NOW(a_zero_norm, o_valid && o_zero_normal, onrm_clear)
    // divider runs only while the sequencer waits on it
    `MUBN_ASSERT_NOW(a_div_owner, div_stat.busy, r_state == S_DIV_RUN)
endmodule
